// ===== sv/tehq_pkg.sv =====
// ============================================================================
// tehq_pkg
// Types and constants shared by the timed-event min-heap queue.
// ============================================================================
package tehq_pkg;

    localparam int ID_BITS    = 6;
    localparam int ID_COUNT   = 64;
    localparam int DELAY_BITS = 20;
    localparam int MS_PER_S   = 1000;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1500;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_POLL     = 2'd2,
        OP_POLL_ALT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_SCHEDULED = 3'd0,
        ST_CANCELLED = 3'd1,
        ST_FIRED     = 3'd2,
        ST_WAITING   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5,
        ST_BAD_ID    = 3'd6
    } t_status;

endpackage

// ===== sv/tehq_if.sv =====
// ============================================================================
// tehq_if
// Valid/ready channel carrying one payload of type T.
// ============================================================================
interface tehq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/timed_event_min_heap_queue_unit.sv =====
// ============================================================================
// timed_event_min_heap_queue_unit
// Deadline scheduler built around a binary min-heap held in RAM, plus an
// id-to-slot map, served by a read-modify-write sequencer.
// ============================================================================
//  channel | dir | fields
//  --------+-----+------------------------------------------------------
//  in      | in  | operation, event_id, delay_s, now_ms
//  out     | out | status, event_id_res, wait_ms, latency_ms, entry_count
//  cfg     | in  | i_cfg_we, i_cfg_wdata (poll_timeout_ms)
//
// One transaction at a time. A waiting or empty poll and a rejected request
// go from S_MAP straight to S_OUT. A schedule climbs level by level. A
// cancel or fire reads victim and last entry and, unless the victim was the
// last entry, puts that entry in the hole, sinks it, rereads the hole and
// climbs from there.
// After reset every slot-map entry is cleared; no input is taken then.
// The result sits in an output register; the next input waits until it is
// taken.
module timed_event_min_heap_queue_unit #(
    parameter int CAPACITY  = 64,
    parameter int TIME_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    tehq_if.sink        in_if,
    tehq_if.source      out_if
);
    import tehq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 1;
    localparam int IW = ID_BITS;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    // heap entry: deadline and owner in one word
    localparam int HW = TIME_BITS + IW;

    typedef enum logic [16:0] {
        S_CLEAR = 17'b00000000000000001,
        S_IDLE  = 17'b00000000000000010,
        S_MAP   = 17'b00000000000000100,
        S_DEC   = 17'b00000000000001000,
        S_RLAST = 17'b00000000000010000,
        S_PUT   = 17'b00000000000100000,
        S_UPRD  = 17'b00000000001000000,
        S_UPCMP = 17'b00000000010000000,
        S_DNRA  = 17'b00000000100000000,
        S_DNRB  = 17'b00000001000000000,
        S_DNCMP = 17'b00000010000000000,
        S_SWAP  = 17'b00000100000000000,
        S_SWAP2 = 17'b00001000000000000,
        S_OUT   = 17'b00010000000000000,
        S_HEAD  = 17'b00100000000000000,
        S_ORGRD = 17'b01000000000000000,
        S_ORGLD = 17'b10000000000000000
    } t_state;

    t_state r_state, n_state;

    // input register
    logic [1:0]           r_op;
    logic [IW-1:0]        r_id;
    logic [DELAY_BITS-1:0] r_delay;
    logic [TIME_BITS-1:0] r_now;

    logic [15:0]  r_timeout;
    logic [CW-1:0] r_cnt, n_cnt;

    // sequencer working registers
    logic [AW-1:0]        r_pos, n_pos;      // current slot
    logic [AW-1:0]        r_oth, n_oth;      // parent or chosen child
    logic [AW-1:0]        r_org, n_org;      // hole slot of a removal
    logic [HW-1:0]        r_cur, n_cur;      // entry at r_pos
    logic [HW-1:0]        r_ent, n_ent;      // entry at r_oth
    logic                 r_up_after, n_up_after;
    logic [IW-1:0]        r_clr, n_clr;

    // output register
    logic                 r_ov;
    t_status              r_st, n_st;
    logic [IW-1:0]        r_rid, n_rid;
    logic [15:0]          r_wait, n_wait;
    logic [31:0]          r_lat, n_lat;
    logic                 ov_set;

    // heap RAM
    logic          h_we;
    logic [AW-1:0] h_wa, h_ra;
    logic [HW-1:0] h_wd, h_rd;
    // slot map RAM
    logic          m_we;
    logic [IW-1:0] m_wa, m_ra;
    logic [SW-1:0] m_wd, m_rd;

    tehq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd)
    );
    tehq_ram #(.WIDTH(SW), .DEPTH(ID_COUNT)) u_map (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(m_rd)
    );

    wire in_fire = in_if.valid && in_if.ready;
    assign in_if.ready = (r_state == S_IDLE) && !r_ov;
    assign out_if.valid = r_ov;
    assign out_if.data.status       = r_st;
    assign out_if.data.event_id_res = r_rid;
    assign out_if.data.wait_ms      = r_wait;
    assign out_if.data.latency_ms   = r_lat;
    assign out_if.data.entry_count  = r_cnt;

    // deadline with saturation
    logic [TIME_BITS+10:0] dl_sum;
    logic [TIME_BITS-1:0]  dl;
    always_comb begin
        dl_sum = {11'd0, r_now} + (TIME_BITS+11)'(r_delay) * (TIME_BITS+11)'(MS_PER_S);
        dl = (dl_sum > {11'd0, TMAX}) ? TMAX : dl_sum[TIME_BITS-1:0];
    end

    wire [TIME_BITS-1:0] cur_dl = r_cur[HW-1:IW];
    wire [IW-1:0]        cur_id = r_cur[IW-1:0];
    wire [TIME_BITS-1:0] ent_dl = r_ent[HW-1:IW];
    wire [TIME_BITS-1:0] hd_dl  = h_rd[HW-1:IW];
    wire [TIME_BITS:0]   gap_late = {1'b0, r_now} - {1'b0, hd_dl};
    wire [TIME_BITS:0]   gap_wait = {1'b0, hd_dl} - {1'b0, r_now};

    // child indices of r_pos, width SW+1 to hold overflow
    wire [AW+1:0] c1 = {1'b0, r_pos, 1'b1};
    wire [AW+1:0] c2 = {1'b0, r_pos, 1'b1} + (AW+2)'(1);

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_pos = r_pos; n_oth = r_oth; n_org = r_org;
        n_cur = r_cur; n_ent = r_ent; n_up_after = r_up_after;
        n_clr = r_clr; n_st = r_st; n_rid = r_rid; n_wait = r_wait; n_lat = r_lat;
        ov_set = 1'b0;
        h_we = 1'b0; h_wa = r_pos; h_wd = r_cur; h_ra = r_pos;
        m_we = 1'b0; m_wa = cur_id; m_wd = SW'(r_pos) + SW'(1); m_ra = r_id;
        unique case (r_state)
            S_CLEAR: begin
                m_we = 1'b1; m_wa = r_clr; m_wd = '0;
                n_clr = r_clr + IW'(1);
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                m_ra = in_if.data.event_id;
                h_ra = '0;
                if (in_fire) n_state = S_MAP;
            end
            S_MAP: begin
                // map read data now valid; heap head too
                n_rid = '0; n_wait = '0; n_lat = '0;
                if (r_op == OP_SCHEDULE) begin
                    n_rid = r_id;
                    if (m_rd != '0) begin
                        n_st = ST_BAD_ID; n_state = S_OUT;
                    end else if (r_cnt == CW'(CAPACITY)) begin
                        n_st = ST_FULL; n_state = S_OUT;
                    end else begin
                        n_st = ST_SCHEDULED;
                        n_pos = r_cnt[AW-1:0];
                        n_cur = {dl, r_id};
                        n_cnt = r_cnt + CW'(1);
                        n_state = S_PUT;
                        n_up_after = 1'b0;
                    end
                end else if (r_op == OP_CANCEL) begin
                    n_rid = r_id;
                    if (m_rd == '0) begin
                        n_st = ST_BAD_ID; n_state = S_OUT;
                    end else if ((m_rd - SW'(1)) >= SW'(r_cnt)) begin
                        m_we = 1'b1; m_wa = r_id; m_wd = '0;
                        n_st = ST_BAD_ID; n_state = S_OUT;
                    end else begin
                        n_st = ST_CANCELLED;
                        n_pos = AW'(m_rd - SW'(1));
                        n_state = S_DEC;
                    end
                end else begin
                    if (r_cnt == '0) begin
                        n_st = ST_EMPTY; n_wait = r_timeout; n_state = S_OUT;
                    end else if (hd_dl <= r_now) begin
                        n_st = ST_FIRED;
                        n_rid = h_rd[IW-1:0];
                        n_lat = (gap_late > (TIME_BITS+1)'(32'hFFFF_FFFF)) ?
                                32'hFFFF_FFFF : gap_late[31:0];
                        n_pos = '0;
                        n_state = S_DEC;
                    end else begin
                        n_st = ST_WAITING;
                        n_wait = (gap_wait > (TIME_BITS+1)'(r_timeout)) ?
                                 r_timeout : gap_wait[15:0];
                        n_state = S_OUT;
                    end
                end
            end
            S_DEC: begin
                // removal: read victim id, then last entry
                h_ra = r_pos;
                n_cnt = r_cnt - CW'(1);
                n_state = S_RLAST;
            end
            S_RLAST: begin
                // h_rd = victim entry; clear its map; read last
                m_we = 1'b1; m_wa = h_rd[IW-1:0]; m_wd = '0;
                h_ra = r_cnt[AW-1:0];
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_cur = h_rd;
                n_org = r_pos;
                if (SW'(r_pos) < SW'(r_cnt)) begin
                    n_up_after = 1'b1;
                    n_state = S_PUT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PUT: begin
                h_we = 1'b1; h_wa = r_pos; h_wd = r_cur;
                m_we = 1'b1; m_wa = cur_id; m_wd = SW'(r_pos) + SW'(1);
                n_state = r_up_after ? S_DNRA : S_UPRD;
            end
            S_UPRD: begin
                if (r_pos == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_oth = (r_pos - AW'(1)) >> 1;
                    h_ra = (r_pos - AW'(1)) >> 1;
                    n_state = S_UPCMP;
                end
            end
            S_UPCMP: begin
                n_ent = h_rd;
                if (hd_dl < cur_dl) begin
                    n_state = S_OUT;
                end else begin
                    n_up_after = 1'b0;
                    n_state = S_SWAP;
                end
            end
            S_DNRA: begin
                if (c1 >= (AW+2)'(r_cnt)) begin
                    n_state = S_ORGRD;
                end else begin
                    h_ra = c1[AW-1:0];
                    n_state = S_DNRB;
                end
            end
            S_DNRB: begin
                n_ent = h_rd; n_oth = c1[AW-1:0];
                h_ra = c2[AW-1:0];
                n_state = S_DNCMP;
            end
            S_DNCMP: begin
                if (c2 < (AW+2)'(r_cnt) && ent_dl > hd_dl) begin
                    n_ent = h_rd; n_oth = c2[AW-1:0];
                    if (cur_dl < hd_dl) begin
                        n_state = S_ORGRD;
                    end else begin
                        n_up_after = 1'b1; n_state = S_SWAP;
                    end
                end else if (cur_dl < ent_dl) begin
                    n_state = S_ORGRD;
                end else begin
                    n_up_after = 1'b1; n_state = S_SWAP;
                end
            end
            S_ORGRD: begin
                // sink done; climb restarts from the hole slot
                h_ra = r_org;
                n_pos = r_org;
                n_state = S_ORGLD;
            end
            S_ORGLD: begin
                n_cur = h_rd;
                n_up_after = 1'b0;
                n_state = S_UPRD;
            end
            S_SWAP: begin
                // other slot gets r_cur
                h_we = 1'b1; h_wa = r_oth; h_wd = r_cur;
                m_we = 1'b1; m_wa = cur_id; m_wd = SW'(r_oth) + SW'(1);
                n_state = S_SWAP2;
            end
            S_SWAP2: begin
                h_we = 1'b1; h_wa = r_pos; h_wd = r_ent;
                m_we = 1'b1; m_wa = r_ent[IW-1:0]; m_wd = SW'(r_pos) + SW'(1);
                n_pos = r_oth;
                n_state = r_up_after ? S_DNRA : S_UPRD;
            end
            S_OUT: begin
                ov_set = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_clr <= '0;
            r_ov <= 1'b0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_clr <= n_clr;
            if (i_cfg_we) r_timeout <= i_cfg_wdata;
            if (ov_set) r_ov <= 1'b1;
            else if (out_if.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op <= in_if.data.operation;
            r_id <= in_if.data.event_id;
            r_delay <= in_if.data.delay_s;
            r_now <= in_if.data.now_ms[TIME_BITS-1:0];
        end
        r_pos <= n_pos; r_oth <= n_oth; r_org <= n_org; r_cur <= n_cur; r_ent <= n_ent;
        r_up_after <= n_up_after;
        r_st <= n_st; r_rid <= n_rid; r_wait <= n_wait; r_lat <= n_lat;
    end

    // no input is taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !in_if.ready) else $error("input taken with result pending");
    // count never exceeds capacity
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY)) else $error("count overflow");
    // a result follows only from work in progress
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_OUT)) else $error("spurious result");
endmodule

// ===== sv/tehq_ram.sv =====
// ============================================================================
// tehq_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module tehq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
